### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// Depends on nothing; take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NWAD_ASSERT_IMPLY(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define NWAD_ASSERT_NEXT(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/nwad_pkg.sv
// Types, widths and constants of the NIS windowed anomaly detector.
// Depends on nothing.
`default_nettype none
package nwad_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int IN_W      = 32;
    localparam int S_W       = 33;
    localparam int ADJ_W     = 67;
    localparam int DET_W     = 102;
    localparam int WV_W      = 101;
    localparam int NUM_W     = 136;
    localparam int ACC_W     = 140;
    localparam int LIMB_W    = 34;
    localparam int MA_W      = 35;
    localparam int MB_W      = 34;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int NIS_W     = 48;
    localparam int NOISE_W   = 31;
    localparam int THR_W     = 47;
    localparam int EPS_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 63;
    localparam int IN_TDATA_W  = 12 * IN_W;
    localparam int OUT_TDATA_W = 104;

    localparam logic [NIS_W-1:0] NIS_MAX = {1'b0, {(NIS_W-1){1'b1}}};
    localparam logic [NIS_W-1:0] NIS_MIN = {1'b1, {(NIS_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOISE_X    = 3'd0,
        REG_NOISE_Y    = 3'd1,
        REG_NOISE_Z    = 3'd2,
        REG_STEP_THR   = 3'd3,
        REG_WINDOW_THR = 3'd4,
        REG_DET_EPS    = 3'd5,
        REG_SING_VALUE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [NOISE_W-1:0] noise_x;
        logic [NOISE_W-1:0] noise_y;
        logic [NOISE_W-1:0] noise_z;
        logic [THR_W-1:0]   step_threshold;
        logic [THR_W-1:0]   window_threshold;
        logic [EPS_W-1:0]   det_epsilon;
        logic [THR_W-1:0]   singular_value;
    } cfg_t;

    // innov[0] sits in the lowest bits, matching the input tdata layout
    typedef struct packed {
        logic [8:0][IN_W-1:0] cov;
        logic [2:0][IN_W-1:0] innov;
    } item_t;

    typedef struct packed {
        logic             singular;
        logic [NIS_W-1:0] nis;
    } res_t;

    // cofactor k = s[p]*s[q] - s[r]*s[t], packed {p, q, r, t}
    function automatic logic [15:0] cof_idx(input logic [3:0] k);
        logic [15:0] r;
        case (k)
            4'd0:    r = {4'd4, 4'd8, 4'd5, 4'd7};
            4'd1:    r = {4'd2, 4'd7, 4'd1, 4'd8};
            4'd2:    r = {4'd1, 4'd5, 4'd2, 4'd4};
            4'd3:    r = {4'd5, 4'd6, 4'd3, 4'd8};
            4'd4:    r = {4'd0, 4'd8, 4'd2, 4'd6};
            4'd5:    r = {4'd2, 4'd3, 4'd0, 4'd5};
            4'd6:    r = {4'd3, 4'd7, 4'd4, 4'd6};
            4'd7:    r = {4'd1, 4'd6, 4'd0, 4'd7};
            4'd8:    r = {4'd0, 4'd4, 4'd1, 4'd3};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/nwad_front.sv
// Front end: accepts input transactions into a two-entry queue.
// Depends on nwad_pkg.
`default_nettype none
module nwad_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nwad_pkg::item_t in_item,
    output logic          item_valid,
    input  logic          item_ready,
    output nwad_pkg::item_t item
);
    import nwad_pkg::*;

    item_t      q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready   = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

### rtl/nwad_engine.sv
// Back end: NIS by a shared multiply-accumulate unit and a serial divider.
// Depends on nwad_pkg.
`default_nettype none
module nwad_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  nwad_pkg::cfg_t  cfg,
    input  logic            item_valid,
    output logic            item_ready,
    input  nwad_pkg::item_t item,
    output logic            res_valid,
    input  logic            res_ready,
    output nwad_pkg::res_t  res
);
    import nwad_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAC, ST_FLUSH, ST_ABS, ST_CHECK, ST_DIV, ST_SAT, ST_DONE
    } state_t;
    typedef enum logic [1:0] {PH_COF, PH_DET, PH_WV, PH_NUM} phase_t;
    typedef enum logic [2:0] {DST_NONE, DST_ADJ, DST_DET, DST_WV, DST_NUM} dst_t;
    typedef struct packed {
        logic       neg;
        logic       clr;
        logic [1:0] limb;
        dst_t       dst;
        logic [3:0] idx;
    } mac_op_t;

    state_t  state_reg;
    phase_t  phase_reg;
    logic [3:0] ci_reg;
    logic [1:0] cj_reg;
    logic [1:0] cl_reg;
    logic       op_vld_reg;
    mac_op_t    op_reg;
    mac_op_t    op_next;
    logic [CNT_W-1:0] cnt_reg;

    logic [S_W-1:0]   s_reg [9];
    logic [IN_W-1:0]  v_reg [3];
    logic [ADJ_W-1:0] adj_reg [9];
    logic [WV_W-1:0]  wv_reg [3];
    logic [DET_W-1:0] det_reg;
    logic [NUM_W-1:0] num_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic [DET_W-1:0] mag_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DET_W-1:0] rem_reg;
    logic             neg_reg;
    res_t             res_reg;

    logic [15:0]      cidx;
    logic [3:0]       adj_sel;
    logic [ADJ_W-1:0] adj_w;
    logic [WV_W-1:0]  wv_w;
    logic [S_W-1:0]   sa;
    logic [S_W-1:0]   sb;
    logic [IN_W-1:0]  vv;
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] shifted;
    logic [ACC_W-1:0] base;
    logic [DET_W:0]   trial;
    logic [DET_W-1:0] eps_ext;
    logic             big;
    logic [NIS_W-1:0] qm;
    logic [NIS_W-1:0] sat_nis;

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res        = res_reg;

    always_comb
    begin
        cidx    = cof_idx(ci_reg);
        adj_sel = 4'(ci_reg * 3 + {2'b00, cj_reg});
        adj_w   = adj_reg[adj_sel];
        wv_w    = wv_reg[ci_reg[1:0]];
        vv      = v_reg[cj_reg];
        sa      = s_reg[cl_reg[0] ? cidx[7:4] : cidx[15:12]];
        sb      = s_reg[cl_reg[0] ? cidx[3:0] : cidx[11:8]];
        mul_a   = '0;
        mul_b   = '0;
        op_next = '0;
        case (phase_reg)
            PH_COF:
            begin
                mul_a       = {{2{sa[S_W-1]}}, sa};
                mul_b       = {sb[S_W-1], sb};
                op_next.neg = cl_reg[0];
                op_next.clr = !cl_reg[0];
                op_next.dst = cl_reg[0] ? DST_ADJ : DST_NONE;
                op_next.idx = ci_reg;
            end
            PH_DET:
            begin
                mul_a = cl_reg[0] ? {{2{adj_w[ADJ_W-1]}}, adj_w[ADJ_W-1:LIMB_W]}
                                  : {1'b0, adj_w[LIMB_W-1:0]};
                mul_b = {s_reg[ci_reg][S_W-1], s_reg[ci_reg]};
                op_next.limb = {1'b0, cl_reg[0]};
                op_next.clr  = (ci_reg == 4'd0) && !cl_reg[0];
                op_next.dst  = ((ci_reg == 4'd2) && cl_reg[0]) ? DST_DET : DST_NONE;
            end
            PH_WV:
            begin
                mul_a = cl_reg[0] ? {{2{adj_w[ADJ_W-1]}}, adj_w[ADJ_W-1:LIMB_W]}
                                  : {1'b0, adj_w[LIMB_W-1:0]};
                mul_b = {{2{vv[IN_W-1]}}, vv};
                op_next.limb = {1'b0, cl_reg[0]};
                op_next.clr  = (cj_reg == 2'd0) && !cl_reg[0];
                op_next.dst  = ((cj_reg == 2'd2) && cl_reg[0]) ? DST_WV : DST_NONE;
                op_next.idx  = ci_reg;
            end
            default:
            begin
                case (cl_reg)
                    2'd0:    mul_a = {1'b0, wv_w[LIMB_W-1:0]};
                    2'd1:    mul_a = {1'b0, wv_w[2*LIMB_W-1:LIMB_W]};
                    default: mul_a = {{2{wv_w[WV_W-1]}}, wv_w[WV_W-1:2*LIMB_W]};
                endcase
                mul_b = {{2{v_reg[ci_reg[1:0]][IN_W-1]}}, v_reg[ci_reg[1:0]]};
                op_next.limb = cl_reg;
                op_next.clr  = (ci_reg == 4'd0) && (cl_reg == 2'd0);
                op_next.dst  = ((ci_reg == 4'd2) && (cl_reg == 2'd2)) ? DST_NUM : DST_NONE;
            end
        endcase
    end

    always_comb
    begin
        ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (op_reg.limb)
            2'd0:    shifted = ext;
            2'd1:    shifted = ext << LIMB_W;
            default: shifted = ext << (2 * LIMB_W);
        endcase
        base     = op_reg.clr ? '0 : acc_reg;
        acc_next = op_reg.neg ? (base - shifted) : (base + shifted);
    end

    always_comb
    begin
        trial   = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, mag_reg};
        eps_ext = {{(DET_W-EPS_W){1'b0}}, cfg.det_epsilon};
        big     = |quo_reg[NUM_W-1:NIS_W];
        qm      = quo_reg[NIS_W-1:0];
        if (neg_reg)
            sat_nis = (big || (qm > NIS_MIN)) ? NIS_MIN : (~qm + 1'b1);
        else
            sat_nis = (big || qm[NIS_W-1]) ? NIS_MAX : qm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_COF;
            ci_reg     <= '0;
            cj_reg     <= '0;
            cl_reg     <= '0;
            cnt_reg    <= '0;
            op_vld_reg <= 1'b0;
        end
        else
        begin
            op_vld_reg <= (state_reg == ST_MAC);
            case (state_reg)
                ST_IDLE:
                    if (item_valid)
                    begin
                        state_reg <= ST_MAC;
                        phase_reg <= PH_COF;
                        ci_reg    <= '0;
                        cj_reg    <= '0;
                        cl_reg    <= '0;
                    end
                ST_MAC:
                    case (phase_reg)
                        PH_COF:
                            if (cl_reg[0])
                            begin
                                cl_reg <= '0;
                                if (ci_reg == 4'd8)
                                begin
                                    ci_reg    <= '0;
                                    phase_reg <= PH_DET;
                                end
                                else
                                    ci_reg <= ci_reg + 4'd1;
                            end
                            else
                                cl_reg <= 2'd1;
                        PH_DET:
                            if (cl_reg[0])
                            begin
                                cl_reg <= '0;
                                if (ci_reg == 4'd2)
                                begin
                                    ci_reg    <= '0;
                                    cj_reg    <= '0;
                                    phase_reg <= PH_WV;
                                end
                                else
                                    ci_reg <= ci_reg + 4'd1;
                            end
                            else
                                cl_reg <= 2'd1;
                        PH_WV:
                            if (cl_reg[0])
                            begin
                                cl_reg <= '0;
                                if (cj_reg == 2'd2)
                                begin
                                    cj_reg <= '0;
                                    if (ci_reg == 4'd2)
                                    begin
                                        ci_reg    <= '0;
                                        phase_reg <= PH_NUM;
                                    end
                                    else
                                        ci_reg <= ci_reg + 4'd1;
                                end
                                else
                                    cj_reg <= cj_reg + 2'd1;
                            end
                            else
                                cl_reg <= 2'd1;
                        default:
                            if (cl_reg == 2'd2)
                            begin
                                cl_reg <= '0;
                                if (ci_reg == 4'd2)
                                    state_reg <= ST_FLUSH;
                                else
                                    ci_reg <= ci_reg + 4'd1;
                            end
                            else
                                cl_reg <= cl_reg + 2'd1;
                    endcase
                ST_FLUSH: state_reg <= ST_ABS;
                ST_ABS:   state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    cnt_reg <= CNT_W'(NUM_W - 1);
                    if ((mag_reg == '0) || (mag_reg < eps_ext))
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= ST_SAT;
                end
                ST_SAT: state_reg <= ST_DONE;
                ST_DONE:
                    if (res_ready)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && item_valid)
        begin
            for (int i = 0; i < 9; i++)
                s_reg[i] <= {item.cov[i][IN_W-1], item.cov[i]};
            s_reg[0] <= {item.cov[0][IN_W-1], item.cov[0]} + {2'b00, cfg.noise_x};
            s_reg[4] <= {item.cov[4][IN_W-1], item.cov[4]} + {2'b00, cfg.noise_y};
            s_reg[8] <= {item.cov[8][IN_W-1], item.cov[8]} + {2'b00, cfg.noise_z};
            for (int i = 0; i < 3; i++)
                v_reg[i] <= item.innov[i];
        end
        prod_reg <= mul_a * mul_b;
        op_reg   <= op_next;
        if (op_vld_reg)
        begin
            acc_reg <= acc_next;
            case (op_reg.dst)
                DST_ADJ: adj_reg[op_reg.idx] <= acc_next[ADJ_W-1:0];
                DST_DET: det_reg <= acc_next[DET_W-1:0];
                DST_WV:  wv_reg[op_reg.idx[1:0]] <= acc_next[WV_W-1:0];
                DST_NUM: num_reg <= acc_next[NUM_W-1:0];
                default: ;
            endcase
        end
        case (state_reg)
            ST_ABS:
            begin
                mag_reg <= det_reg[DET_W-1] ? (~det_reg + 1'b1) : det_reg;
                quo_reg <= num_reg[NUM_W-1] ? (~num_reg + 1'b1) : num_reg;
                neg_reg <= det_reg[DET_W-1] ^ num_reg[NUM_W-1];
                rem_reg <= '0;
            end
            ST_CHECK:
            begin
                res_reg.singular <= 1'b1;
                res_reg.nis      <= {1'b0, cfg.singular_value};
            end
            ST_DIV:
            begin
                if (!trial[DET_W])
                    rem_reg <= trial[DET_W-1:0];
                else
                    rem_reg <= {rem_reg[DET_W-2:0], quo_reg[NUM_W-1]};
                quo_reg <= {quo_reg[NUM_W-2:0], !trial[DET_W]};
            end
            ST_SAT:
            begin
                res_reg.singular <= 1'b0;
                res_reg.nis      <= sat_nis;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/nwad_window.sv
// Window stage: ring of recent NIS values, running mean, alarms, output register.
// Depends on nwad_pkg.
`default_nettype none
module nwad_window #(
    parameter int WINDOW_DEPTH = nwad_pkg::WINDOW_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  nwad_pkg::cfg_t cfg,
    input  logic           res_valid,
    output logic           res_ready,
    input  nwad_pkg::res_t res,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [nwad_pkg::NIS_W-1:0] out_nis,
    output logic [nwad_pkg::NIS_W-1:0] out_anis,
    output logic           out_step_alarm,
    output logic           out_window_alarm,
    output logic           out_singular
);
    import nwad_pkg::*;

    localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = NIS_W + FILL_W;
    localparam int CNT_W  = $clog2(SUM_W);

    typedef enum logic [2:0] {
        W_IDLE, W_READ, W_UPD, W_ABS, W_DIV, W_SIGN, W_OUT
    } state_t;

    state_t            state_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NIS_W-1:0]  ring_mem [WINDOW_DEPTH];
    logic [NIS_W-1:0]  rd_reg;
    logic [NIS_W-1:0]  nis_reg;
    logic              sing_reg;
    logic              sneg_reg;
    logic [FILL_W-1:0] rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [NIS_W-1:0]  anis_reg;
    logic              full;
    logic [SUM_W-1:0]  sum_next;
    logic [FILL_W:0]   trial;

    assign res_ready = (state_reg == W_IDLE);
    assign full      = (fill_reg == FILL_W'(WINDOW_DEPTH));

    always_comb
    begin
        sum_next = sum_reg + {{FILL_W{nis_reg[NIS_W-1]}}, nis_reg};
        if (full)
            sum_next = sum_next - {{FILL_W{rd_reg[NIS_W-1]}}, rd_reg};
        trial = {rem_reg, quo_reg[SUM_W-1]} - {1'b0, fill_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if ((state_reg == W_OUT) && (!out_valid || out_ready))
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                W_IDLE:
                    if (res_valid)
                        state_reg <= W_READ;
                W_READ: state_reg <= W_UPD;
                W_UPD:
                begin
                    sum_reg <= sum_next;
                    if (head_reg == HEAD_W'(WINDOW_DEPTH - 1))
                        head_reg <= '0;
                    else
                        head_reg <= head_reg + 1'b1;
                    if (!full)
                        fill_reg <= fill_reg + 1'b1;
                    state_reg <= W_ABS;
                end
                W_ABS:
                begin
                    cnt_reg   <= CNT_W'(SUM_W - 1);
                    state_reg <= W_DIV;
                end
                W_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= W_SIGN;
                end
                W_SIGN: state_reg <= W_OUT;
                W_OUT:
                    if (!out_valid || out_ready)
                        state_reg <= W_IDLE;
                default: state_reg <= W_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            W_IDLE:
                if (res_valid)
                begin
                    nis_reg  <= res.nis;
                    sing_reg <= res.singular;
                end
            W_READ: rd_reg <= ring_mem[head_reg];
            W_UPD:  ring_mem[head_reg] <= nis_reg;
            W_ABS:
            begin
                sneg_reg <= sum_reg[SUM_W-1];
                quo_reg  <= sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
                rem_reg  <= '0;
            end
            W_DIV:
            begin
                if (!trial[FILL_W])
                    rem_reg <= trial[FILL_W-1:0];
                else
                    rem_reg <= {rem_reg[FILL_W-2:0], quo_reg[SUM_W-1]};
                quo_reg <= {quo_reg[SUM_W-2:0], !trial[FILL_W]};
            end
            W_SIGN:
                anis_reg <= sneg_reg ? (~quo_reg[NIS_W-1:0] + 1'b1) : quo_reg[NIS_W-1:0];
            W_OUT:
                if (!out_valid || out_ready)
                begin
                    out_nis          <= nis_reg;
                    out_anis         <= anis_reg;
                    out_step_alarm   <= $signed(nis_reg) > $signed({1'b0, cfg.step_threshold});
                    out_window_alarm <= $signed(anis_reg) >
                                        $signed({1'b0, cfg.window_threshold});
                    out_singular     <= sing_reg;
                end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/nis_windowed_anomaly_detector_unit.sv
// Top level of the NIS windowed anomaly detector: configuration and stream ports.
// Depends on nwad_pkg, nwad_front, nwad_engine, nwad_window.
//
// Each input transaction carries a position innovation and the 3x3 covariance block; the
// block returns one result with NIS, windowed mean NIS, two alarms and a singular flag.
// An item occupies the NIS engine for 51 issues of the shared 35x34 multiply-accumulate
// unit, the check states and a 136-step restoring divider. A singular item skips the
// divider. The window stage then computes its mean with a serial divider, overlapped
// with the next item in the engine, so the engine can take a new item while the window
// stage still works on the last. Two items queue at the input while the engine is busy.
`default_nettype none
module nis_windowed_anomaly_detector_unit #(
    parameter int WINDOW_DEPTH = nwad_pkg::WINDOW_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // innov_x, innov_y, innov_z, cov_xx, cov_xy, cov_xz, cov_yx, cov_yy, cov_yz,
    // cov_zx, cov_zy, cov_zz
    input  logic [nwad_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // nis, anis, step_alarm, window_alarm, zero fill
    output logic [nwad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // singular
    output logic [0:0] m_axis_tuser,
    input  logic cfg_we,
    input  logic [nwad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nwad_pkg::CFG_W-1:0] cfg_data
);
    import nwad_pkg::*;

    cfg_t  cfg_reg;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;
    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic [NIS_W-1:0] o_nis;
    logic [NIS_W-1:0] o_anis;
    logic  o_step;
    logic  o_win;
    logic  o_sing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_x          <= NOISE_W'(65536);
            cfg_reg.noise_y          <= NOISE_W'(65536);
            cfg_reg.noise_z          <= NOISE_W'(65536);
            cfg_reg.step_threshold   <= THR_W'(743178);
            cfg_reg.window_threshold <= THR_W'(511836);
            cfg_reg.det_epsilon      <= EPS_W'(281);
            cfg_reg.singular_value   <= THR_W'(64'd65536000000);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NOISE_X:    cfg_reg.noise_x          <= cfg_data[NOISE_W-1:0];
                REG_NOISE_Y:    cfg_reg.noise_y          <= cfg_data[NOISE_W-1:0];
                REG_NOISE_Z:    cfg_reg.noise_z          <= cfg_data[NOISE_W-1:0];
                REG_STEP_THR:   cfg_reg.step_threshold   <= cfg_data[THR_W-1:0];
                REG_WINDOW_THR: cfg_reg.window_threshold <= cfg_data[THR_W-1:0];
                REG_DET_EPS:    cfg_reg.det_epsilon      <= cfg_data[EPS_W-1:0];
                REG_SING_VALUE: cfg_reg.singular_value   <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    nwad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (item_t'(s_axis_tdata)),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item)
    );

    nwad_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    nwad_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_nis          (o_nis),
        .out_anis         (o_anis),
        .out_step_alarm   (o_step),
        .out_window_alarm (o_win),
        .out_singular     (o_sing)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-2*NIS_W-2){1'b0}}, o_win, o_step, o_anis, o_nis};
    assign m_axis_tuser = o_sing;

endmodule
`default_nettype wire

### rtl/nwad_checker.sv
// Port-level checker for the NIS windowed anomaly detector, bound to the top level.
// Depends on nwad_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module nwad_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [nwad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0] m_axis_tuser
);
    // queue holds two; engine, window stage and output register hold one each
    localparam logic [2:0] MAX_PENDING = 3'd5;

    logic [2:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_acc && !out_acc)
            pend_reg <= pend_reg + 3'd1;
        else if (out_acc && !in_acc)
            pend_reg <= pend_reg - 3'd1;
    end

    `NWAD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `NWAD_ASSERT_IMPLY(a_out_has_item, clk, rst_n, m_axis_tvalid, pend_reg != 3'd0)
    `NWAD_ASSERT_IMPLY(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= MAX_PENDING)

endmodule

bind nis_windowed_anomaly_detector_unit nwad_checker u_nwad_checker (.*);
`default_nettype wire

### bench/tb.sv
// Testbench of nis_windowed_anomaly_detector_unit: stream stimulus, idling and result checks.
// Predicts NIS, windowed mean and alarms with exact wide arithmetic; needs nwad_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
    import nwad_pkg::*;

    localparam int DEPTH = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [47:0] nis;
        logic [47:0] anis;
        logic        step_alarm;
        logic        window_alarm;
        logic        singular;
    } nis_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    logic [30:0] noise_x, noise_y, noise_z;
    logic [46:0] step_thr, window_thr, sentinel;
    logic [62:0] det_eps;
    logic signed [47:0] window_vals [DEPTH];
    int unsigned win_head;
    int unsigned win_fill;
    logic signed [63:0] win_sum;

    nis_result_t expected_results [$];
    int error_count;
    longint cycle_count;
    int burst_left;
    bit stall_mode;

    nis_windowed_anomaly_detector_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $realtime);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic nis_result_t predict_nis(input logic [IN_TDATA_W-1:0] item);
        logic signed [191:0] s [9];
        logic signed [191:0] v [3];
        logic signed [191:0] adj [9];
        logic signed [191:0] det, num, mag, nmag, q;
        logic signed [63:0] nis_v, anis_v;
        nis_result_t r;
        int k;
        begin
            for (k = 0; k < 3; k++)
                v[k] = $signed(item[32*k +: 32]);
            for (k = 0; k < 9; k++)
                s[k] = $signed(item[32*(k+3) +: 32]);
            s[0] = s[0] + $signed({1'b0, noise_x});
            s[4] = s[4] + $signed({1'b0, noise_y});
            s[8] = s[8] + $signed({1'b0, noise_z});
            adj[0] = s[4]*s[8] - s[5]*s[7];
            adj[1] = s[2]*s[7] - s[1]*s[8];
            adj[2] = s[1]*s[5] - s[2]*s[4];
            adj[3] = s[5]*s[6] - s[3]*s[8];
            adj[4] = s[0]*s[8] - s[2]*s[6];
            adj[5] = s[2]*s[3] - s[0]*s[5];
            adj[6] = s[3]*s[7] - s[4]*s[6];
            adj[7] = s[1]*s[6] - s[0]*s[7];
            adj[8] = s[0]*s[4] - s[1]*s[3];
            det = adj[0]*s[0] + adj[3]*s[1] + adj[6]*s[2];
            mag = (det < 0) ? -det : det;
            if (mag == 0 || mag < $signed({129'd0, det_eps}))
            begin
                r.singular = 1'b1;
                nis_v = $signed({17'd0, sentinel});
            end
            else
            begin
                r.singular = 1'b0;
                num = 0;
                for (k = 0; k < 9; k++)
                    num = num + adj[k] * v[k/3] * v[k%3];
                nmag = (num < 0) ? -num : num;
                q = nmag / mag;
                if ((num < 0) != (det < 0))
                    nis_v = (q > 192'sh800000000000) ? -64'sh800000000000 : -q[63:0];
                else
                    nis_v = (q > 192'sh7FFFFFFFFFFF) ? 64'sh7FFFFFFFFFFF : q[63:0];
            end
            if (win_fill >= DEPTH)
                win_sum = win_sum - window_vals[win_head];
            else
                win_fill++;
            window_vals[win_head] = nis_v[47:0];
            win_sum = win_sum + nis_v;
            win_head = (win_head + 1) % DEPTH;
            anis_v = win_sum / $signed({32'd0, win_fill});
            r.nis = nis_v[47:0];
            r.anis = anis_v[47:0];
            r.step_alarm = nis_v > $signed({17'd0, step_thr});
            r.window_alarm = anis_v > $signed({17'd0, window_thr});
            return r;
        end
    endfunction

    always @(posedge clk)
    begin
        nis_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result tdata=%h", $realtime, m_axis_tdata);
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_axis_tdata[47:0] !== e.nis)
                begin
                    error_count++;
                    $display("%0t nis exp %h got %h", $realtime, e.nis, m_axis_tdata[47:0]);
                end
                if (m_axis_tdata[95:48] !== e.anis)
                begin
                    error_count++;
                    $display("%0t anis exp %h got %h", $realtime, e.anis, m_axis_tdata[95:48]);
                end
                if (m_axis_tdata[96] !== e.step_alarm)
                begin
                    error_count++;
                    $display("%0t step_alarm exp %b got %b", $realtime, e.step_alarm,
                        m_axis_tdata[96]);
                end
                if (m_axis_tdata[97] !== e.window_alarm)
                begin
                    error_count++;
                    $display("%0t window_alarm exp %b got %b", $realtime, e.window_alarm,
                        m_axis_tdata[97]);
                end
                if (m_axis_tuser[0] !== e.singular)
                begin
                    error_count++;
                    $display("%0t singular exp %b got %b", $realtime, e.singular,
                        m_axis_tuser[0]);
                end
            end
        end
    end

    // receiver stall pattern: alternate quiet stretches and random backpressure
    always @(negedge clk)
    begin
        if (($urandom % 64) == 0)
            stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? (($urandom % 4) == 0) : 1'b1;
    end

    task automatic send_item(input logic [IN_TDATA_W-1:0] item);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 300);
                repeat (gap) @(negedge clk);
            end
            burst_left--;
            s_axis_tdata = item;
            s_axis_tvalid = 1'b1;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            expected_results.push_back(predict_nis(item));
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
            case (idx)
                REG_NOISE_X:    noise_x = value[30:0];
                REG_NOISE_Y:    noise_y = value[30:0];
                REG_NOISE_Z:    noise_z = value[30:0];
                REG_STEP_THR:   step_thr = value[46:0];
                REG_WINDOW_THR: window_thr = value[46:0];
                REG_DET_EPS:    det_eps = value[62:0];
                REG_SING_VALUE: sentinel = value[46:0];
                default: ;
            endcase
        end
    endtask

    task automatic write_bad_index(input logic [CFG_W-1:0] value);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= 3'd7;
            cfg_data <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic drain;
        begin
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (300) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_word;
        case ($urandom % 6)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 65536 * 4);
            3: return -$urandom_range(0, 65536 * 4);
            default: return $urandom;
        endcase
    endfunction

    // covariance near a realistic symmetric positive definite block
    function automatic logic [IN_TDATA_W-1:0] plausible_item;
        logic [IN_TDATA_W-1:0] it;
        logic [31:0] a;
        int k;
        begin
            for (k = 0; k < 3; k++)
                it[32*k +: 32] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            for (k = 0; k < 9; k++)
                it[32*(k+3) +: 32] = 0;
            for (k = 0; k < 3; k++)
                it[32*(3 + 4*k) +: 32] = $urandom_range(1, 1 << 20);
            a = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            it[32*4 +: 32] = a;
            it[32*6 +: 32] = a;
            return it;
        end
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_item;
        logic [IN_TDATA_W-1:0] it;
        int k;
        begin
            for (k = 0; k < 12; k++)
                it[32*k +: 32] = rand_word();
            return it;
        end
    endfunction

    task automatic test_directed;
        logic [IN_TDATA_W-1:0] it;
        int k;
        begin
            send_item('0);
            it = '0;
            it[31:0] = 32'h0001_0000;
            send_item(it);
            for (k = 0; k < 12; k++)
                it[32*k +: 32] = 32'h7FFF_FFFF;
            send_item(it);
            for (k = 0; k < 12; k++)
                it[32*k +: 32] = 32'h8000_0000;
            send_item(it);
            it = '1;
            send_item(it);
            it = '0;
            it[31:0] = 32'h7FFF_FFFF;
            it[63:32] = 32'h8000_0000;
            it[32*7 +: 32] = 32'hFFFF_0000;
            send_item(it);
            it = '0;
            it[31:0] = 32'h7FFF_FFFF;
            it[32*3 +: 32] = 32'hFFFF_0000;
            it[32*7 +: 32] = 32'hFFFE_0000;
            send_item(it);
            for (k = 0; k < 12; k++)
                send_item(plausible_item());
            drain();
        end
    endtask

    task automatic test_singular;
        logic [IN_TDATA_W-1:0] it;
        begin
            write_reg(REG_DET_EPS, '0);
            write_reg(REG_NOISE_X, '0);
            write_reg(REG_NOISE_Y, '0);
            write_reg(REG_NOISE_Z, '0);
            send_item('0);
            it = '0;
            it[31:0] = 32'h0002_0000;
            it[32*3 +: 32] = 32'h0001_0000;
            send_item(it);
            drain();
            write_reg(REG_SING_VALUE, {16'd0, 47'h7FFF_FFFF_FFFF});
            write_reg(REG_STEP_THR, '0);
            write_reg(REG_WINDOW_THR, '0);
            send_item('0);
            drain();
            write_reg(REG_DET_EPS, {1'b0, 62'h3FFF_FFFF_FFFF_FFFF});
            write_reg(REG_SING_VALUE, '0);
            send_item(plausible_item());
            drain();
            write_bad_index('1);
            write_reg(REG_DET_EPS, '1);
            write_reg(REG_SING_VALUE, {16'd0, 47'h2AAA_AAAA_AAAA});
            send_item(plausible_item());
            send_item(random_item());
            drain();
        end
    endtask

    task automatic random_phase(input int count);
        int k;
        begin
            for (k = 0; k < count; k++)
                send_item(($urandom % 4 == 0) ? random_item() : plausible_item());
            drain();
        end
    endtask

    task automatic test_random_configs;
        begin
            write_reg(REG_NOISE_X, 63'd65536);
            write_reg(REG_NOISE_Y, 63'd65536);
            write_reg(REG_NOISE_Z, 63'd65536);
            write_reg(REG_STEP_THR, 63'd743178);
            write_reg(REG_WINDOW_THR, 63'd511836);
            write_reg(REG_DET_EPS, 63'd281);
            write_reg(REG_SING_VALUE, 63'd65536000000);
            random_phase(250);
            write_reg(REG_NOISE_X, {32'd0, 31'h7FFF_FFFF});
            write_reg(REG_NOISE_Y, {32'hFFFF_FFFF, 31'h7FFF_FFFF});
            write_reg(REG_NOISE_Z, 63'($urandom));
            write_reg(REG_STEP_THR, 63'({$urandom, $urandom}));
            write_reg(REG_WINDOW_THR, 63'({$urandom, $urandom}) & 63'hFFFF_FFFF);
            write_reg(REG_DET_EPS, 63'({$urandom, $urandom}) & 63'hFFFF_FFFF_FFFF);
            write_reg(REG_SING_VALUE, 63'({$urandom, $urandom}));
            random_phase(200);
            write_reg(REG_NOISE_X, 63'd1);
            write_reg(REG_NOISE_Y, 63'd300);
            write_reg(REG_NOISE_Z, 63'd65536);
            write_reg(REG_STEP_THR, 63'd131072);
            write_reg(REG_WINDOW_THR, {16'd0, 47'h7FFF_FFFF_FFFF});
            write_reg(REG_DET_EPS, 63'd1 << 40);
            random_phase(230);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = REG_NOISE_X;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        stall_mode = 1'b0;
        noise_x = 31'd65536;
        noise_y = 31'd65536;
        noise_z = 31'd65536;
        step_thr = 47'd743178;
        window_thr = 47'd511836;
        det_eps = 63'd281;
        sentinel = 47'd65536000000;
        win_head = 0;
        win_fill = 0;
        win_sum = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_singular();
        test_random_configs();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/nwad_pkg.sv
rtl/nwad_front.sv
rtl/nwad_engine.sv
rtl/nwad_window.sv
rtl/nis_windowed_anomaly_detector_unit.sv
rtl/nwad_checker.sv
bench/tb.sv
